### rtl/core/pidsc_pkg.sv
// Shared types, widths, register indexes and reset values for the PID speed controller.
// No dependencies; compiled first.
package pidsc_pkg;

    // Fixed-point formats
    localparam int GAIN_FRAC_BITS  = 16;
    localparam int SPEED_FRAC_BITS = 4;
    localparam int FRAC_BITS       = GAIN_FRAC_BITS + SPEED_FRAC_BITS;

    // Field and datapath widths
    localparam int SPEED_W   = 16;
    localparam int GAIN_W    = 24;
    localparam int LIMIT_W   = 13;
    localparam int DRIVE_W   = 14;
    localparam int ERR_W     = SPEED_W + 2;
    localparam int DERR_W    = ERR_W + 1;
    localparam int PROD_W    = GAIN_W + 1 + ERR_W;
    localparam int DPROD_W   = GAIN_W + 1 + DERR_W;
    localparam int SUM_W     = 40;
    localparam int SUM_LO_W  = SUM_W / 2;
    localparam int RC_PROD_W = GAIN_W + 1 + SUM_LO_W + 1;
    localparam int ISUM_W    = 64;
    localparam int U_W       = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = CFG_IDX_W'(4);

    // Register reset values
    localparam logic signed [SPEED_W-1:0] RST_TARGET_SPEED = SPEED_W'(800);
    localparam logic [GAIN_W-1:0]         RST_PROP_GAIN    = GAIN_W'(1114112);
    localparam logic [GAIN_W-1:0]         RST_INTEG_GAIN   = GAIN_W'(9503);
    localparam logic [GAIN_W-1:0]         RST_DERIV_GAIN   = GAIN_W'(0);
    localparam logic [LIMIT_W-1:0]        RST_DRIVE_LIMIT  = LIMIT_W'(8191);

    // Saturation bounds
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [ISUM_W-1:0] TERM_LIM = ISUM_W'(1) << 60;
    localparam logic signed [U_W-1:0]    HALF_LSB = U_W'(1) << (FRAC_BITS - 1);

    typedef logic signed [SPEED_W-1:0] t_speed;
    typedef logic signed [DRIVE_W-1:0] t_drive;

    // Sequencer that rebuilds the integral product after an integ_gain write
    typedef enum logic [2:0] {
        RC_IDLE = 3'b001,
        RC_LO   = 3'b010,
        RC_HI   = 3'b100
    } t_recalc_state;

endpackage

### rtl/core/pidsc_if.sv
// Valid/ready channel interfaces of the PID speed controller: sample in, drive out, config.
// Depends on pidsc_pkg.
interface pidsc_in_if;
    import pidsc_pkg::*;
    logic   valid;
    logic   ready;
    t_speed measured_speed;

    modport source (output valid, output measured_speed, input ready);
    modport sink   (input valid, input measured_speed, output ready);
endinterface

interface pidsc_out_if;
    import pidsc_pkg::*;
    logic   valid;
    logic   ready;
    t_drive drive;
    logic   clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface pidsc_cfg_if;
    import pidsc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/pid_speed_controller_antiwindup.sv
// Top level of the PID speed controller with conditional-integration anti-windup.
// Depends on pidsc_pkg and the channel interfaces in pidsc_if.
//
// One measured speed sample (signed Q12.4) enters per beat and one drive beat leaves for
// it: the block takes a sample every cycle unless the sink stalls or an integral rebuild
// runs, and the drive passes the input stage and the result register. The rate is set by
// the integral loop: the accumulator and its product with integ_gain are kept as a pair
// of registers, so each sample closes the loop with one 25x18 product, one 64-bit add,
// the limit compare and the select. The P and D products run beside it. A write to
// integ_gain (register 2) rebuilds the stored product with one shared 25x21 multiplier;
// input ready is low meanwhile. Other register writes take effect at once. Configuration
// writes are always ready and must land while no sample is in flight. A raw drive beyond
// +-drive_limit is clamped, the integration of that sample is dropped and clamped is set.
module pid_speed_controller_antiwindup (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pidsc_in_if.sink      i_speed,
    pidsc_out_if.source   o_drive,
    pidsc_cfg_if.sink     i_cfg
);
    import pidsc_pkg::*;

    // Configuration registers
    logic signed [SPEED_W-1:0] r_target_speed;
    logic [GAIN_W-1:0]         r_prop_gain;
    logic [GAIN_W-1:0]         r_integ_gain;
    logic [GAIN_W-1:0]         r_deriv_gain;
    logic [LIMIT_W-1:0]        r_drive_limit;

    // Input stage
    logic                     r_s1_valid;
    logic signed [ERR_W-1:0]  r_s1_err;
    logic signed [DERR_W-1:0] r_s1_derr;
    logic signed [ERR_W-1:0]  r_prev_err;

    // Controller state: running error sum and integ_gain * error sum
    logic signed [SUM_W-1:0]  r_error_sum;
    logic signed [ISUM_W-1:0] r_isum;
    t_recalc_state            r_rc_state;

    // Result register
    logic   r_out_valid;
    t_drive r_drive;
    logic   r_clamped;

    logic cfg_fire;
    logic in_fire;
    logic s2_advance;
    logic s2_load;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid & i_cfg.ready;

    // Hold the result until the sink takes it; the input stage moves on whenever
    // the result register is free or being emptied in this cycle.
    assign s2_advance    = !r_out_valid || o_drive.ready;
    assign s2_load       = s2_advance && r_s1_valid;
    assign i_speed.ready = (r_rc_state == RC_IDLE) && (!r_s1_valid || s2_advance);
    assign in_fire       = i_speed.valid & i_speed.ready;

    assign o_drive.valid   = r_out_valid;
    assign o_drive.drive   = r_drive;
    assign o_drive.clamped = r_clamped;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_speed <= RST_TARGET_SPEED;
            r_prop_gain    <= RST_PROP_GAIN;
            r_integ_gain   <= RST_INTEG_GAIN;
            r_deriv_gain   <= RST_DERIV_GAIN;
            r_drive_limit  <= RST_DRIVE_LIMIT;
        end else if (cfg_fire) begin
            case (i_cfg.index)
                REG_TARGET_SPEED: r_target_speed <= i_cfg.data[SPEED_W-1:0];
                REG_PROP_GAIN:    r_prop_gain    <= i_cfg.data[GAIN_W-1:0];
                REG_INTEG_GAIN:   r_integ_gain   <= i_cfg.data[GAIN_W-1:0];
                REG_DERIV_GAIN:   r_deriv_gain   <= i_cfg.data[GAIN_W-1:0];
                REG_DRIVE_LIMIT:  r_drive_limit  <= i_cfg.data[LIMIT_W-1:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ---------------- input stage: error and error step ----------------
    logic signed [ERR_W-1:0]  n_err;
    logic signed [DERR_W-1:0] n_derr;

    assign n_err  = ERR_W'(r_target_speed) - ERR_W'(i_speed.measured_speed);
    // The previous error follows every sample, clamped or not, so track it here.
    assign n_derr = DERR_W'(n_err) - DERR_W'(r_prev_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_prev_err <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                r_prev_err <= n_err;
            end else if (s2_advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_err  <= n_err;
            r_s1_derr <= n_derr;
        end
    end

    // ---------------- compute stage ----------------
    logic signed [PROD_W-1:0]  p_term;
    logic signed [PROD_W-1:0]  ie_term;
    logic signed [DPROD_W-1:0] d_term;
    logic signed [SUM_W:0]     trial_raw;
    logic signed [ISUM_W-1:0]  igain_ext;
    logic signed [SUM_W-1:0]   n_error_sum;
    logic signed [ISUM_W-1:0]  n_isum;
    logic signed [ISUM_W-1:0]  i_term;
    logic signed [U_W-1:0]     u_raw;
    logic signed [U_W-1:0]     u_half;
    logic signed [U_W-1:0]     u_counts;
    logic signed [U_W-1:0]     lim_pos;
    logic signed [U_W-1:0]     lim_neg;
    t_drive                    n_drive;
    logic                      n_clamped;

    assign p_term    = $signed({1'b0, r_prop_gain}) * r_s1_err;
    assign ie_term   = $signed({1'b0, r_integ_gain}) * r_s1_err;
    assign d_term    = $signed({1'b0, r_deriv_gain}) * r_s1_derr;
    assign trial_raw = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(r_s1_err);
    assign igain_ext = ISUM_W'({1'b0, r_integ_gain});

    // Saturate the trial sum; the integral product at the bounds is a shift and subtract.
    always_comb begin
        if (trial_raw > (SUM_W+1)'(SUM_MAX)) begin
            n_error_sum = SUM_MAX;
            n_isum      = (igain_ext <<< (SUM_W - 1)) - igain_ext;
        end else if (trial_raw < (SUM_W+1)'(SUM_MIN)) begin
            n_error_sum = SUM_MIN;
            n_isum      = -(igain_ext <<< (SUM_W - 1));
        end else begin
            n_error_sum = trial_raw[SUM_W-1:0];
            n_isum      = r_isum + ISUM_W'(ie_term);
        end
    end

    always_comb begin
        if (n_isum > TERM_LIM) begin
            i_term = TERM_LIM;
        end else if (n_isum < -TERM_LIM) begin
            i_term = -TERM_LIM;
        end else begin
            i_term = n_isum;
        end
    end

    assign u_raw    = i_term + U_W'(p_term) + U_W'(d_term);
    assign lim_pos  = U_W'({1'b0, r_drive_limit}) <<< FRAC_BITS;
    assign lim_neg  = -lim_pos;
    assign u_half   = u_raw + HALF_LSB;
    assign u_counts = u_half >>> FRAC_BITS;

    // Clamp against the exact bound, else round half up to whole counts.
    always_comb begin
        if (u_raw > lim_pos) begin
            n_drive   = DRIVE_W'(r_drive_limit);
            n_clamped = 1'b1;
        end else if (u_raw < lim_neg) begin
            n_drive   = -DRIVE_W'(r_drive_limit);
            n_clamped = 1'b1;
        end else begin
            n_drive   = u_counts[DRIVE_W-1:0];
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    // ---------------- integral product rebuild ----------------
    // After an integ_gain write, form gain * error_sum in two halves: the low half unsigned,
    // then the signed high half shifted up and added.
    logic signed [SUM_LO_W:0]    rc_operand;
    logic signed [RC_PROD_W-1:0] rc_prod;

    always_comb begin
        if (r_rc_state == RC_HI) begin
            rc_operand = (SUM_LO_W+1)'($signed(r_error_sum[SUM_W-1:SUM_LO_W]));
        end else begin
            rc_operand = {1'b0, r_error_sum[SUM_LO_W-1:0]};
        end
    end

    assign rc_prod = $signed({1'b0, r_integ_gain}) * rc_operand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc_state <= RC_IDLE;
        end else if (cfg_fire && (i_cfg.index == REG_INTEG_GAIN)) begin
            r_rc_state <= RC_LO;
        end else begin
            case (r_rc_state)
                RC_LO:   r_rc_state <= RC_HI;
                RC_HI:   r_rc_state <= RC_IDLE;
                default: r_rc_state <= RC_IDLE;
            endcase
        end
    end

    // Advance the accumulator only on unclamped samples; a rebuild loads the integral product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum <= '0;
            r_isum      <= '0;
        end else if (r_rc_state == RC_LO) begin
            r_isum <= ISUM_W'(rc_prod);
        end else if (r_rc_state == RC_HI) begin
            r_isum <= r_isum + (ISUM_W'(rc_prod) <<< SUM_LO_W);
        end else if (s2_load && !n_clamped) begin
            r_error_sum <= n_error_sum;
            r_isum      <= n_isum;
        end
    end

endmodule

### rtl/core/pidsc_checker.sv
// Port-level checks for the PID speed controller, attached to the top level by bind.
// Depends on pidsc_pkg and pid_speed_controller_antiwindup.
module pidsc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input pidsc_pkg::t_drive                   i_drive,
    input logic                                i_clamped,
    input logic                                i_cfg_valid,
    input logic                                i_cfg_ready,
    input logic [pidsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [pidsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pidsc_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    t_drive             lim_pos;
    t_drive             lim_neg;
    logic               cfg_fire;

    assign cfg_fire = i_cfg_valid & i_cfg_ready;
    assign lim_pos  = DRIVE_W'(r_limit);
    assign lim_neg  = -lim_pos;

    // Shadow of the drive limit as written through the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= RST_DRIVE_LIMIT;
        end else if (cfg_fire && (i_cfg_index == REG_DRIVE_LIMIT)) begin
            r_limit <= i_cfg_data[LIMIT_W-1:0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_drive) && $stable(i_clamped))
        else $error("stalled drive beat changed");

    a_drive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_drive <= lim_pos) && (i_drive >= lim_neg))
        else $error("drive outside the limit");

    a_clamp_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_clamped |-> (i_drive == lim_pos) || (i_drive == lim_neg))
        else $error("clamped drive not at a bound");

    a_gain_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire && (i_cfg_index == REG_INTEG_GAIN) |=> !i_in_ready ##1 !i_in_ready)
        else $error("sample accepted during integral rebuild");

endmodule

bind pid_speed_controller_antiwindup pidsc_checker u_pidsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_speed.ready),
    .i_out_valid (o_drive.valid),
    .i_out_ready (o_drive.ready),
    .i_drive     (o_drive.drive),
    .i_clamped   (o_drive.clamped),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_cfg_data  (i_cfg.data)
);

### dv/pidsc_drive_checker.sv
`timescale 1ns / 100ps
// Drive scoreboard for the PID speed controller: mirrors the registers and the loop state,
// predicts each drive beat from the accepted speed sample and compares it field by field.
// Depends on pidsc_pkg and the channel interfaces in pidsc_if.
module pidsc_drive_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pidsc_in_if  i_speed,
    pidsc_out_if i_drive,
    pidsc_cfg_if i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import pidsc_pkg::*;

    typedef struct packed {
        t_drive drive;
        logic   clamped;
    } t_drive_beat;

    localparam longint ACC_MAX    = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint ACC_MIN    = -(longint'(1) <<< (SUM_W - 1));
    localparam longint INTEG_CAP  = longint'(1) <<< 60;
    localparam longint HALF_COUNT = longint'(1) <<< (FRAC_BITS - 1);

    // Register mirror and loop state, all held as plain 64-bit integers
    longint set_speed;
    longint kp;
    longint ki;
    longint kd;
    longint drive_lim;
    longint error_sum;
    longint prev_err;

    t_drive_beat drive_expect_q[$];
    int          n_fail = 0;

    // One control tick: error, trial integration, three terms, limit test, rounding.
    function automatic t_drive_beat next_drive(input t_speed meas);
        longint      err;
        longint      trial;
        longint      p_term;
        longint      i_term;
        longint      d_term;
        longint      raw;
        longint      bound;
        longint      counts;
        t_drive_beat beat;
        err   = set_speed - longint'(meas);
        trial = error_sum + err;
        if (trial > ACC_MAX) trial = ACC_MAX;
        if (trial < ACC_MIN) trial = ACC_MIN;
        p_term = kp * err;
        i_term = ki * trial;
        if (i_term > INTEG_CAP) i_term = INTEG_CAP;
        if (i_term < -INTEG_CAP) i_term = -INTEG_CAP;
        d_term = kd * (err - prev_err);
        raw    = p_term + i_term + d_term;
        bound  = drive_lim <<< FRAC_BITS;
        beat.clamped = 1'b1;
        if (raw > bound) begin
            counts = drive_lim;
        end else if (raw < -bound) begin
            counts = -drive_lim;
        end else begin
            counts = (raw + HALF_COUNT) >>> FRAC_BITS;
            beat.clamped = 1'b0;
        end
        // A clamped tick drops its integration; the derivative history always advances
        if (!beat.clamped) error_sum = trial;
        prev_err = err;
        beat.drive = t_drive'(counts);
        return beat;
    endfunction

    always @(posedge i_clk) begin
        t_drive_beat want;
        if (!i_rst_n) begin
            set_speed = longint'(RST_TARGET_SPEED);
            kp        = longint'(RST_PROP_GAIN);
            ki        = longint'(RST_INTEG_GAIN);
            kd        = longint'(RST_DERIV_GAIN);
            drive_lim = longint'(RST_DRIVE_LIMIT);
            error_sum = 0;
            prev_err  = 0;
            drive_expect_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_TARGET_SPEED: set_speed = longint'(t_speed'(i_cfg.data[SPEED_W-1:0]));
                    REG_PROP_GAIN:    kp        = longint'(i_cfg.data[GAIN_W-1:0]);
                    REG_INTEG_GAIN:   ki        = longint'(i_cfg.data[GAIN_W-1:0]);
                    REG_DERIV_GAIN:   kd        = longint'(i_cfg.data[GAIN_W-1:0]);
                    REG_DRIVE_LIMIT:  drive_lim = longint'(i_cfg.data[LIMIT_W-1:0]);
                    default: ;
                endcase
            end
            if (i_speed.valid && i_speed.ready) begin
                drive_expect_q.push_back(next_drive(i_speed.measured_speed));
            end
            if (i_drive.valid && i_drive.ready) begin
                if (drive_expect_q.size() == 0) begin
                    $display("%0t: unexpected drive beat: drive %0d clamped %0b",
                             $time, i_drive.drive, i_drive.clamped);
                    n_fail++;
                end else begin
                    want = drive_expect_q.pop_front();
                    if (i_drive.drive !== want.drive) begin
                        $display("%0t: drive mismatch: expected %0d actual %0d",
                                 $time, want.drive, i_drive.drive);
                        n_fail++;
                    end
                    if (i_drive.clamped !== want.clamped) begin
                        $display("%0t: clamped mismatch: expected %0b actual %0b",
                                 $time, want.clamped, i_drive.clamped);
                        n_fail++;
                    end
                end
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= drive_expect_q.size();
    end

endmodule

### dv/pid_speed_controller_antiwindup_tb.sv
`timescale 1ns / 100ps
// Top of the PID speed controller testbench: clock, reset, speed and register stimulus,
// random stalls on both channels and the verdict. Depends on pidsc_pkg, pidsc_if,
// the controller RTL and pidsc_drive_checker.
module pid_speed_controller_antiwindup_tb;
    import pidsc_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 98;
    localparam int MAX_GAP         = 30;
    localparam int DRAIN_CYCLES    = 20;
    localparam int TIMEOUT_NS      = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pidsc_in_if  speed_ch ();
    pidsc_out_if drive_ch ();
    pidsc_cfg_if cfg_ch ();

    // Idle percentages for the sample source and the drive sink
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Beat bookkeeping: sent is bumped by the stimulus, received by the sink process
    int n_sent     = 0;
    int n_recv     = 0;
    int n_clamped  = 0;
    int n_settings = 0;

    int fail_count;
    int pending;

    always #HALF_PERIOD i_clk = ~i_clk;

    pid_speed_controller_antiwindup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_speed (speed_ch),
        .o_drive (drive_ch),
        .i_cfg   (cfg_ch)
    );

    pidsc_drive_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_speed      (speed_ch),
        .i_drive      (drive_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Drive sink: stall at random each cycle, count every drive beat taken
    always @(posedge i_clk) begin
        drive_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && drive_ch.valid && drive_ch.ready) begin
            n_recv <= n_recv + 1;
            if (drive_ch.clamped) n_clamped <= n_clamped + 1;
        end
    end

    // Offer one speed sample and hold it until accepted. Valid stays high on return so the
    // next sample can follow back to back; a random idle gap lowers it first.
    task automatic send_sample(input t_speed meas);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            speed_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        speed_ch.valid          <= 1'b1;
        speed_ch.measured_speed <= meas;
        @(posedge i_clk);
        while (!speed_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    // Drop the sample valid and hold until every drive beat owed has come back.
    task automatic quiesce();
        speed_ch.valid <= 1'b0;
        while (n_recv != n_sent) @(posedge i_clk);
    endtask

    // One register write beat; valid drops and stays low behind it, so it never toggles in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int                 tgt_now;
        int                 m;
        int                 span;
        int                 mode;
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [LIMIT_W-1:0] lim;
        t_speed             last_meas;

        // Every input known from time zero
        i_rst_n                 = 1'b0;
        speed_ch.valid          = 1'b0;
        speed_ch.measured_speed = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_TARGET_SPEED;
        cfg_ch.data             = '0;
        drive_ch.ready          = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------- directed part, sender 17% idle, sink 66% idle ----------------
        send_idle_pct = 17;
        recv_idle_pct = 66;

        // Reset settings: zero error, both speed extremes, small error, zero speed
        send_sample(t_speed'(800));
        send_sample(t_speed'(-32768));
        send_sample(t_speed'(32767));
        send_sample(t_speed'(790));
        send_sample(t_speed'(0));
        quiesce();

        // Out-of-range indexes must be ignored; setpoint write carries junk upper bits
        write_reg(REG_DRIVE_LIMIT + CFG_IDX_W'(1), 24'h5A5A5A);
        write_reg(REG_DRIVE_LIMIT + CFG_IDX_W'(2), CFG_DATA_W'($urandom));
        write_reg(REG_DRIVE_LIMIT + CFG_IDX_W'(3), CFG_DATA_W'($urandom));
        write_reg(REG_TARGET_SPEED, 24'hAB8000);
        n_settings++;
        send_sample(t_speed'(32767));
        send_sample(t_speed'(-32768));
        quiesce();

        // Zero limit with only the derivative active: a step clamps to 0, a hold does not
        write_reg(REG_PROP_GAIN, '0);
        write_reg(REG_INTEG_GAIN, '0);
        write_reg(REG_DERIV_GAIN, '1);
        write_reg(REG_DRIVE_LIMIT, 24'hFFE000);
        n_settings++;
        send_sample(t_speed'(-32768));
        send_sample(t_speed'(0));
        send_sample(t_speed'(0));
        quiesce();

        // Half-count rounding in both directions with a gain of one half
        write_reg(REG_TARGET_SPEED, '0);
        write_reg(REG_PROP_GAIN, CFG_DATA_W'(524288));
        write_reg(REG_DERIV_GAIN, '0);
        write_reg(REG_DRIVE_LIMIT, CFG_DATA_W'(100));
        n_settings++;
        send_sample(t_speed'(-1));
        send_sample(t_speed'(1));
        send_sample(t_speed'(-3));
        send_sample(t_speed'(3));
        quiesce();

        // Unity gain: raw drive lands exactly on the limit, then one past it, both signs
        write_reg(REG_PROP_GAIN, CFG_DATA_W'(1048576));
        n_settings++;
        send_sample(t_speed'(-100));
        send_sample(t_speed'(-101));
        send_sample(t_speed'(100));
        send_sample(t_speed'(101));
        quiesce();

        // All gains at full scale, top setpoint, widest limit
        write_reg(REG_TARGET_SPEED, CFG_DATA_W'(32767));
        write_reg(REG_PROP_GAIN, '1);
        write_reg(REG_INTEG_GAIN, '1);
        write_reg(REG_DERIV_GAIN, '1);
        write_reg(REG_DRIVE_LIMIT, CFG_DATA_W'(8191));
        n_settings++;
        send_sample(t_speed'(32767));
        send_sample(t_speed'(32766));
        send_sample(t_speed'(-32768));

        // ---------------- random part ----------------
        // Phases 0-3 keep the sink slow, 4-7 the source, 8-11 run with no idling at all.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct = (ph < 4) ? 17 : (ph < 8) ? 66 : 0;
            recv_idle_pct = (ph < 4) ? 66 : (ph < 8) ? 17 : 0;
            quiesce();

            // Mostly moderate gains so the loop spends time both inside and on the limit
            tgt_now = int'($urandom_range(0, 65535)) - 32768;
            kp      = GAIN_W'($urandom_range(0, 1 << 21));
            ki      = GAIN_W'($urandom_range(0, 1 << 16));
            kd      = GAIN_W'($urandom_range(0, 1 << 20));
            lim     = LIMIT_W'($urandom_range(0, 8191));
            case (ph % 6)
                1: begin
                    // integral and derivative action, no proportional term, against the widest limit
                    kp  = '0;
                    lim = '1;
                end
                3: lim = '0;
                5: begin
                    kp      = '1;
                    ki      = '1;
                    kd      = '1;
                    tgt_now = (ph < 6) ? 32767 : -32768;
                end
                default: ;
            endcase

            if ($urandom_range(3) == 0) begin
                write_reg(REG_DRIVE_LIMIT + CFG_IDX_W'($urandom_range(1, 3)),
                          CFG_DATA_W'($urandom));
            end
            write_reg(REG_TARGET_SPEED, {8'($urandom), 16'(tgt_now)});
            write_reg(REG_PROP_GAIN, kp);
            write_reg(REG_INTEG_GAIN, ki);
            write_reg(REG_DERIV_GAIN, kd);
            write_reg(REG_DRIVE_LIMIT, {11'($urandom), lim});
            n_settings++;

            // Speed trajectories: settle near the setpoint, drift, hold, jump, hit extremes
            last_meas = t_speed'(tgt_now);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                mode = int'($urandom_range(99));
                if (mode < 45) begin
                    span = 1 << $urandom_range(0, 12);
                    m    = tgt_now + int'($urandom_range(0, span)) - span / 2;
                end else if (mode < 65) begin
                    m = int'(last_meas) + int'($urandom_range(0, 64)) - 32;
                end else if (mode < 75) begin
                    m = int'(last_meas);
                end else if (mode < 92) begin
                    m = int'($urandom_range(0, 65535)) - 32768;
                end else begin
                    case ($urandom_range(3))
                        0:       m = -32768;
                        1:       m = 32767;
                        2:       m = 0;
                        default: m = -1;
                    endcase
                end
                if (m > 32767) m = 32767;
                if (m < -32768) m = -32768;
                last_meas = t_speed'(m);
                send_sample(last_meas);
            end
        end

        // Drain: wait for every owed beat, then hold a while to catch strays
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d speed samples over %0d register settings, %0d drive beats clamped",
                 n_sent, n_settings, n_clamped);
        $display("stalls ran source-heavy and sink-heavy, then back to back with no idling");
        if (pending != 0) $display("%0d expected drive beats never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS pid_speed_controller_antiwindup");
        end else begin
            $display("FAIL pid_speed_controller_antiwindup");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run
    initial begin
        #TIMEOUT_NS;
        $display("timeout after %0d samples sent, %0d drive beats received", n_sent, n_recv);
        $display("FAIL pid_speed_controller_antiwindup");
        $finish;
    end

endmodule

### files.f
rtl/core/pidsc_pkg.sv
rtl/core/pidsc_if.sv
rtl/core/pid_speed_controller_antiwindup.sv
rtl/core/pidsc_checker.sv
dv/pidsc_drive_checker.sv
dv/pid_speed_controller_antiwindup_tb.sv
